/* design/mf1d_pkg.sv */
// Shared types and constants for the 1-D median filter.
// No dependencies; imported by mf1d_median and median_filter_1d_top.
package mf1d_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int HALF_W       = 3;
    localparam int MAX_HALF_DEF = 7;
    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       seq_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median;
        logic                       final_res;
    } t_res_item;

endpackage

/* design/mf1d_median.sv */
// Rank-select median over the first 2m+1 window entries.
// Depends on mf1d_pkg for the sample width.
module mf1d_median #(
    parameter int MAX_HALF = mf1d_pkg::MAX_HALF_DEF
) (
    input  logic signed [mf1d_pkg::SAMPLE_W-1:0] i_win [2*MAX_HALF+1],
    input  logic [$clog2(MAX_HALF+1)-1:0]        i_half,
    output logic signed [mf1d_pkg::SAMPLE_W-1:0] o_median
);
    import mf1d_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
    localparam int RK_W      = $clog2(WIN_DEPTH);

    logic [WIN_DEPTH-1:0] active;
    logic [RK_W-1:0]      rank [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] pick;
    logic [RK_W-1:0]      half_rk;

    // Mark entries inside the current window
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            active[i] = (i <= 2 * int'(i_half));
        end
    end

    // Rank each entry by how many active entries sort ahead of it;
    // ties break on position so every rank is distinct
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WIN_DEPTH; j++) begin
                if (j != i && active[j] &&
                    ((i_win[j] < i_win[i]) || ((i_win[j] == i_win[i]) && (j < i)))) begin
                    rank[i] = rank[i] + RK_W'(1);
                end
            end
        end
    end

    // Select the active entry whose rank equals m
    assign half_rk = RK_W'(i_half);

    always_comb begin
        o_median = '0;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            pick[i] = active[i] && (rank[i] == half_rk);
            if (pick[i]) begin
                o_median = o_median | i_win[i];
            end
        end
    end

endmodule

/* design/median_filter_1d_top.sv */
// Streaming 1-D median filter, zero-padded window of 2m+1 samples.
// Samples shift into the window; its median loads the result register.
// One sample per cycle; held off on stalls, m-zero seq_end flush and clear.
// Reset (synchronous, i_rst_n low): window zeroed, count cleared, m = 1.
// Depends on mf1d_pkg and mf1d_median.
module median_filter_1d_top #(
    parameter int MAX_HALF = mf1d_pkg::MAX_HALF_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mf1d_pkg::t_in_item          i_in_data,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output mf1d_pkg::t_res_item         o_res_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mf1d_pkg::HALF_W-1:0] i_cfg_data
);
    import mf1d_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
    localparam int MH_W      = $clog2(MAX_HALF + 1);
    localparam logic [MH_W-1:0] MAX_M = MH_W'(MAX_HALF);

    logic [HALF_W-1:0]          r_half;
    logic signed [SAMPLE_W-1:0] r_win  [WIN_DEPTH];
    logic signed [SAMPLE_W-1:0] n_win  [WIN_DEPTH];
    logic [MH_W-1:0]            r_recv, n_recv;
    logic [MH_W-1:0]            r_flush_left, n_flush_left;
    logic                       r_emit, n_emit;
    logic                       r_final, n_final;
    logic                       r_out_valid;
    t_res_item                  r_out;

    logic [MH_W-1:0]            m_eff;
    logic [MH_W-1:0]            recv_inc;
    logic                       adv_out, s1_free, in_ready, in_acc, flush_step;
    logic signed [SAMPLE_W-1:0] shift_val;
    logic signed [SAMPLE_W-1:0] med;

    // Clamp the half-width to what the window holds
    assign m_eff = (int'(r_half) > MAX_HALF) ? MAX_M : MH_W'(r_half);

    // Handshake control
    assign adv_out    = r_emit && (!r_out_valid || i_res_ready);
    assign s1_free    = !r_emit || adv_out;
    assign in_ready   = (r_flush_left == '0) && !r_final && s1_free;
    assign in_acc     = i_in_valid && in_ready;
    assign flush_step = (r_flush_left != '0) && s1_free;
    assign recv_inc   = (r_recv == MAX_M) ? r_recv : r_recv + MH_W'(1);
    assign shift_val  = in_acc ? i_in_data.sample : '0;

    // Window shift, flush sequencing and end-of-sequence clear
    always_comb begin
        n_win        = r_win;
        n_recv       = r_recv;
        n_flush_left = r_flush_left;
        n_emit       = r_emit && !adv_out;
        n_final      = r_final;
        if (r_final && adv_out) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                n_win[i] = '0;
            end
            n_recv  = '0;
            n_final = 1'b0;
        end else if (in_acc || flush_step) begin
            n_win[0] = shift_val;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                n_win[i] = r_win[i-1];
            end
            n_emit = (r_recv >= m_eff);
            n_recv = recv_inc;
            if (in_acc) begin
                if (i_in_data.seq_end) begin
                    if (m_eff == '0) begin
                        n_final = 1'b1;
                    end else begin
                        n_flush_left = m_eff;
                    end
                end
            end else begin
                n_flush_left = r_flush_left - MH_W'(1);
                n_final      = (r_flush_left == MH_W'(1));
            end
        end
    end

    mf1d_median #(
        .MAX_HALF (MAX_HALF)
    ) u_median (
        .i_win    (r_win),
        .i_half   (m_eff),
        .o_median (med)
    );

    // Hold state, window and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half       <= HALF_RESET;
            r_recv       <= '0;
            r_flush_left <= '0;
            r_emit       <= 1'b0;
            r_final      <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_half <= i_cfg_data;
            end
            r_win        <= n_win;
            r_recv       <= n_recv;
            r_flush_left <= n_flush_left;
            r_emit       <= n_emit;
            r_final      <= n_final;
            if (adv_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_out.median    <= med;
            r_out.final_res <= r_final;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_res_valid = r_out_valid;
    assign o_res_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

/* tb/sv/median_filter_1d_top_test.sv */
// Self-checking testbench for median_filter_1d_top: streams signed sample sequences,
// predicts each zero-padded window median in-bench and compares every result beat.
// Depends on mf1d_pkg and the median_filter_1d_top design sources.
module median_filter_1d_top_test;
    import mf1d_pkg::*;

    localparam int HALF_MAX    = MAX_HALF_DEF;
    localparam int WIN_LEN     = 2 * HALF_MAX + 1;
    localparam int DRAIN_WAIT  = 2 * HALF_MAX + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 330;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_res_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [HALF_W-1:0]     i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_res_valid;
    t_res_item             o_res_data;
    logic                  o_cfg_ready;

    // Predictor state: window newest first, samples seen this sequence, half-width
    logic signed [SAMPLE_W-1:0] win_q [WIN_LEN];
    int                         seen_cnt;
    logic [HALF_W-1:0]          half_cfg;
    t_res_item                  expected_results [$];

    // Traffic control and bookkeeping
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_phase = 0;
    bit          gaps_on     = 1'b0;
    int          burst_left  = 1;
    int          cycle_cnt   = 0;
    int          mismatch_cnt = 0;
    int          samples_sent = 0;
    int          results_checked = 0;
    int          seq_cnt     = 0;
    int          cfg_writes  = 0;
    bit [7:0]    halves_used = '0;
    t_res_item   exp_head;

    median_filter_1d_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_data  (o_res_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_cnt, expected_results.size());
            $display("** median_filter_1d_top: FAILED **");
            $finish;
        end
    end

    // Drive result-side backpressure
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            STALL_NONE: begin
                i_res_ready <= 1'b1;
            end
            STALL_RANDOM: begin
                i_res_ready <= ($urandom_range(0, 9) > 2);
            end
            default: begin
                i_res_ready <= ((stall_phase % 11) >= 4);
            end
        endcase
    end

    // Compare each result beat with the oldest expected median
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: median %0d final %0d",
                             $signed(o_res_data.median), o_res_data.final_res);
            end else begin
                exp_head = expected_results.pop_front();
                results_checked++;
                if (o_res_data.median !== exp_head.median ||
                    o_res_data.final_res !== exp_head.final_res) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result %0d: median exp %0d got %0d, final exp %0d got %0d",
                                 results_checked, $signed(exp_head.median),
                                 $signed(o_res_data.median), exp_head.final_res,
                                 o_res_data.final_res);
                end
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] window_median(int m);
        logic signed [SAMPLE_W-1:0] srt [WIN_LEN];
        logic signed [SAMPLE_W-1:0] v;
        int i;
        int k;
        for (i = 0; i < WIN_LEN; i++)
            srt[i] = win_q[i];
        // Insertion sort over the active 2m+1 entries
        for (i = 1; i < 2 * m + 1; i++) begin
            v = srt[i];
            k = i;
            while (k > 0 && srt[k-1] > v) begin
                srt[k] = srt[k-1];
                k--;
            end
            srt[k] = v;
        end
        return srt[m];
    endfunction

    function automatic void shift_window(logic signed [SAMPLE_W-1:0] v);
        int i;
        for (i = WIN_LEN - 1; i > 0; i--)
            win_q[i] = win_q[i-1];
        win_q[0] = v;
    endfunction

    function automatic void clear_window();
        int i;
        for (i = 0; i < WIN_LEN; i++)
            win_q[i] = '0;
        seen_cnt = 0;
    endfunction

    // Work out the medians that one accepted sample releases
    function automatic void predict_medians(t_in_item it);
        logic signed [SAMPLE_W-1:0] meds [$];
        t_res_item r;
        int m;
        int j;
        int k;
        m = (half_cfg > HALF_MAX) ? HALF_MAX : int'(half_cfg);
        j = seen_cnt;
        shift_window(it.sample);
        if (j >= m)
            meds = {meds, window_median(m)};
        if (it.seq_end) begin
            // Flush trailing positions with zero padding
            for (k = 1; k <= m; k++) begin
                shift_window('0);
                if (j + k >= m)
                    meds = {meds, window_median(m)};
            end
            clear_window();
        end else begin
            seen_cnt = (j < HALF_MAX) ? j + 1 : j;
        end
        for (k = 0; k < meds.size(); k++) begin
            r.median    = meds[k];
            r.final_res = it.seq_end && (k == meds.size() - 1);
            expected_results = {expected_results, r};
        end
    endfunction

    // Send one sample beat; hold valid across a burst, drop it for a gap
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic last);
        t_in_item it;
        it.sample  = s;
        it.seq_end = last;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_medians(it);
        samples_sent++;
        if (last)
            seq_cnt++;
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Hold off input until every expected median has arrived, then let the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_half(logic [HALF_W-1:0] m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        half_cfg = m;
        halves_used[m] = 1'b1;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Reset half-width of one, extremes and sign boundaries
    task automatic test_default_half();
        halves_used[HALF_RESET] = 1'b1;
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        wait_drained();
    endtask

    // Zero half-width passes each sample straight through
    task automatic test_zero_half();
        write_half(3'd0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sd5, 1'b1);
        wait_drained();
    endtask

    // Widest window: results only start after seven samples, then flush seven
    task automatic test_max_half();
        int i;
        write_half(3'd7);
        for (i = 0; i < 9; i++)
            send_sample((i % 2) ? 16'sh7FFF : SAMPLE_W'(16'sh8000 + i), i == 8);
        wait_drained();
    endtask

    // Sequences shorter than m+1 emit everything on their last beat
    task automatic test_short_sequences();
        write_half(3'd5);
        send_sample(16'sd1234, 1'b1);
        send_sample(-16'sd300, 1'b0);
        send_sample(16'sd77, 1'b1);
        wait_drained();
    endtask

    // Change the half-width in the middle of a sequence
    task automatic test_midsequence_change();
        write_half(3'd2);
        send_sample(16'sd10, 1'b0);
        send_sample(-16'sd20, 1'b0);
        send_sample(16'sd30, 1'b0);
        wait_drained();
        write_half(3'd6);
        send_sample(16'sd40, 1'b0);
        send_sample(-16'sd50, 1'b1);
        wait_drained();
    endtask

    // Random sequences under varied half-widths and traffic
    task automatic test_random_sequences();
        int len;
        int i;
        int sent;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_drained();
                write_half(HALF_W'($urandom_range(0, 7)));
            end
            gaps_on    = ($urandom_range(0, 3) != 0);
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                               : $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
                if (len > 4 && i == len / 2 && $urandom_range(0, 7) == 0) begin
                    wait_drained();
                    write_half(HALF_W'($urandom_range(0, 7)));
                end
                send_sample(pick_sample(), i == len - 1);
            end
            sent += len;
        end
        wait_drained();
    endtask

    initial begin
        clear_window();
        half_cfg = HALF_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_half();
        test_zero_half();
        test_max_half();
        test_short_sequences();
        test_midsequence_change();
        write_half(3'd7);
        write_half(3'd0);
        test_random_sequences();
        stall_mode = STALL_NONE;
        wait_drained();

        $display("covered %0d samples in %0d sequences, %0d medians checked",
                 samples_sent, seq_cnt, results_checked);
        $display("half-width writes: %0d, settings seen mask %b, mismatches %0d",
                 cfg_writes, halves_used, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("** median_filter_1d_top: PASSED **");
        end else begin
            $display("** median_filter_1d_top: FAILED **");
        end
        $finish;
    end

endmodule
